// File: rtl/dual_adc_channel_scan_sequencer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the channel scan sequencer
// Small wrappers for clocked implications on clk, gated off while rst is high.
// ----------------------------------------------------------------------------
`ifndef DUAL_ADC_CHANNEL_SCAN_SEQUENCER_CORE_ASSERT_SVH
`define DUAL_ADC_CHANNEL_SCAN_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define DACSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dacss: same-cycle check failed");

// Next-cycle implication.
`define DACSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dacss: next-cycle check failed");

`endif

// File: rtl/dacss_pkg.sv
// ----------------------------------------------------------------------------
// Channel scan sequencer package
// Phase, command and code types, constants and the structs shared by modules.
// ----------------------------------------------------------------------------
package dacss_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_OPEN   = 4'd1,
    PH_SETTLE = 4'd2,
    PH_TRIG   = 4'd3,
    PH_WAIT   = 4'd4,
    PH_READ_I = 4'd5,
    PH_READ_V = 4'd6,
    PH_CLOSE  = 4'd7,
    PH_HOLD   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_LOCK    = 2'd1,
    ACT_TRIGGER = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STORE_NONE    = 2'd0,
    STORE_CURRENT = 2'd1,
    STORE_VOLTAGE = 2'd2,
    STORE_BUILTIN = 2'd3
  } store_kind_t;

  typedef enum logic [1:0] {
    REINIT_NONE    = 2'd0,
    REINIT_CURRENT = 2'd1,
    REINIT_VOLTAGE = 2'd2
  } reinit_t;

  typedef enum logic [1:0] {
    CFG_CHANNEL_COUNT  = 2'd0,
    CFG_SETTLE_TICKS   = 2'd1,
    CFG_BUILTIN_MODE   = 2'd2,
    CFG_DISCHARGE_PARK = 2'd3
  } cfg_index_t;

  localparam logic [8:0] MISS_LIMIT    = 9'd255;
  localparam logic [8:0] MISS_MAX      = 9'd511;
  localparam logic [6:0] PARK_ADDR     = 7'h7F;
  localparam logic [3:0] BUILTIN_SPLIT = 4'd4;
  localparam logic [4:0] BUILTIN_COUNT = 5'd8;
  localparam logic [4:0] LAST_CHANNEL  = 5'd15;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  scan_channel;
    logic [15:0] settle_count;
    logic [8:0]  miss_count;
    logic        lock_mode;
    logic        lock_switched;
    logic [3:0]  locked_channel;
    logic [3:0]  saved_channel;
    logic        ready_flag;
    logic        suspend_flag;
  } seq_state_t;

  typedef struct packed {
    logic [4:0]  channel_count;
    logic [15:0] settle_ticks;
    logic        builtin_volt_mode;
    logic        discharge_park_enable;
  } seq_cfg_t;

  typedef struct packed {
    action_t     action;
    logic [3:0]  lock_channel;
    logic        ready_current_n;
    logic        ready_voltage_n;
    logic [23:0] sample_code;
  } step_in_t;

  typedef struct packed {
    logic        mux_open;
    logic [6:0]  mux_address;
    logic        trigger_convert;
    store_kind_t store_kind;
    logic [3:0]  store_channel;
    logic [23:0] store_code;
    reinit_t     reinit_converter;
    logic        suspend_aux;
    logic        lock_ready;
    phase_t      phase;
  } step_out_t;

endpackage

// File: rtl/dacss_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one tick or command to the sequencer.
// ----------------------------------------------------------------------------
interface dacss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  lock_channel;
  logic        ready_current_n;
  logic        ready_voltage_n;
  logic [23:0] sample_code;

  modport source (
    output valid, action, lock_channel, ready_current_n, ready_voltage_n, sample_code,
    input  ready
  );
  modport sink (
    input  valid, action, lock_channel, ready_current_n, ready_voltage_n, sample_code,
    output ready
  );
endinterface

// File: rtl/dacss_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the mux, trigger and store actions of one step.
// ----------------------------------------------------------------------------
interface dacss_out_if;
  logic        valid;
  logic        ready;
  logic        mux_open;
  logic [6:0]  mux_address;
  logic        trigger_convert;
  logic [1:0]  store_kind;
  logic [3:0]  store_channel;
  logic [23:0] store_code;
  logic [1:0]  reinit_converter;
  logic        suspend_aux;
  logic        lock_ready;
  logic [3:0]  phase;

  modport source (
    output valid, mux_open, mux_address, trigger_convert, store_kind, store_channel,
           store_code, reinit_converter, suspend_aux, lock_ready, phase,
    input  ready
  );
  modport sink (
    input  valid, mux_open, mux_address, trigger_convert, store_kind, store_channel,
           store_code, reinit_converter, suspend_aux, lock_ready, phase,
    output ready
  );
endinterface

// File: rtl/dual_adc_channel_scan_sequencer_core.sv
// ----------------------------------------------------------------------------
// Dual converter channel scan sequencer core
// Steps a mux scan with paired current/voltage conversions, one request a step.
// ----------------------------------------------------------------------------
// Usage: each request on the request channel is either a tick (action 0) or a
// lock command (enter, trigger, release). Every request yields exactly one
// response on the result channel, carrying the mux drive, the converter
// trigger, an optional store of a conversion code, a converter reinit code and
// the sequencer status (suspend, lock ready, phase) after that step.
// The response is registered twice: the request is held in the request
// register, then its step result in the result register, where it can be taken.
// Throughput, set by the single step of next-state logic between those two
// registers, is one request per cycle while the receiver takes each response.
// The request register accepts a new request while the result register still
// holds an untaken response, so a stalled receiver leaves room for one buffered request
// before ready drops; nothing is lost or repeated under any stall pattern.
// Reset (rst, synchronous) empties both registers, returns the sequencer to
// idle on channel 0 and loads the register defaults: 8 channels, settle of 8
// ticks, built-in voltage mode and discharge park off. Configuration writes
// take effect at the edge where cfg_write is high and are meant for idle time.
// ----------------------------------------------------------------------------
`include "dual_adc_channel_scan_sequencer_core_assert.svh"

module dual_adc_channel_scan_sequencer_core
  import dacss_pkg::*;
#(
  parameter int MAX_CHANNELS = 16
) (
  input  logic              clk,
  input  logic              rst,
  dacss_in_if.sink          request,
  dacss_out_if.source       result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  // The scan wraps at the configured count (built-in count in built-in mode), clipped
  // to the channel capacity of the board and to the 16 slots a 4-bit channel number can name.
  localparam logic [4:0] CHANNEL_CAP = (MAX_CHANNELS < 16) ? 5'(MAX_CHANNELS) : 5'd16;

  seq_state_t st;
  seq_state_t st_next;
  seq_cfg_t   cfg;
  step_in_t   ir;
  logic       ir_valid;
  step_out_t  res;
  logic       res_valid;
  step_out_t  step_out;
  logic [4:0] raw_count;
  logic [4:0] eff_count;
  logic       adv;
  logic       fire;

  // The result register can take a new response when it is empty or its
  // current one is being taken this cycle; the request register drains into
  // it under the same condition.
  assign adv  = !res_valid || result.ready;
  assign fire = ir_valid && adv;
  assign request.ready = !ir_valid || adv;

  assign raw_count = cfg.builtin_volt_mode ? BUILTIN_COUNT : cfg.channel_count;
  assign eff_count = (raw_count > CHANNEL_CAP) ? CHANNEL_CAP : raw_count;

  dacss_step u_step (
    .st        (st),
    .cfg       (cfg),
    .eff_count (eff_count),
    .item      (ir),
    .st_next   (st_next),
    .out       (step_out)
  );

  // Control state, sequencer state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid  <= 1'b0;
      res_valid <= 1'b0;
      st        <= '{phase: PH_IDLE, default: '0};
      cfg.channel_count         <= 5'd8;
      cfg.settle_ticks          <= 16'd8;
      cfg.builtin_volt_mode     <= 1'b0;
      cfg.discharge_park_enable <= 1'b0;
    end else begin
      if (request.ready) begin
        ir_valid <= request.valid;
      end
      if (adv) begin
        res_valid <= ir_valid;
      end
      if (fire) begin
        st <= st_next;
      end
      if (cfg_write) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_CHANNEL_COUNT:  cfg.channel_count         <= cfg_data[4:0];
          CFG_SETTLE_TICKS:   cfg.settle_ticks          <= cfg_data;
          CFG_BUILTIN_MODE:   cfg.builtin_volt_mode     <= cfg_data[0];
          CFG_DISCHARGE_PARK: cfg.discharge_park_enable <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers need no reset; they are qualified by the valid bits.
  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      ir.action          <= action_t'(request.action);
      ir.lock_channel    <= request.lock_channel;
      ir.ready_current_n <= request.ready_current_n;
      ir.ready_voltage_n <= request.ready_voltage_n;
      ir.sample_code     <= request.sample_code;
    end
    if (fire) begin
      res <= step_out;
    end
  end

  assign result.valid            = res_valid;
  assign result.mux_open         = res.mux_open;
  assign result.mux_address      = res.mux_address;
  assign result.trigger_convert  = res.trigger_convert;
  assign result.store_kind       = res.store_kind;
  assign result.store_channel    = res.store_channel;
  assign result.store_code       = res.store_code;
  assign result.reinit_converter = res.reinit_converter;
  assign result.suspend_aux      = res.suspend_aux;
  assign result.lock_ready       = res.lock_ready;
  assign result.phase            = res.phase;

  // A converter reinit always drops the sequencer back to idle.
  `DACSS_ASSERT_NOW(a_reinit_idles, res_valid && res.reinit_converter != REINIT_NONE, res.phase == PH_IDLE)
  // A trigger step leaves the sequencer waiting with a fresh miss count.
  `DACSS_ASSERT_NOW(a_trigger_clears, res_valid && res.trigger_convert, res.phase == PH_WAIT && st.miss_count == 9'd0)
  // Entering lock mode takes hold in the state after the step.
  `DACSS_ASSERT_NEXT(a_lock_enter, fire && ir.action == ACT_LOCK, st.lock_mode && st.suspend_flag)
  // A held request that cannot drain must not be overwritten.
  `DACSS_ASSERT_NOW(a_no_overrun, ir_valid && !adv, !request.ready)

endmodule

// File: rtl/dacss_step.sv
// ----------------------------------------------------------------------------
// Sequencer step logic
// Next state and step outputs for one tick or command, purely combinational.
// ----------------------------------------------------------------------------
module dacss_step
  import dacss_pkg::*;
(
  input  seq_state_t st,
  input  seq_cfg_t   cfg,
  input  logic [4:0] eff_count,
  input  step_in_t   item,
  output seq_state_t st_next,
  output step_out_t  out
);

  logic [15:0] settle_inc;
  logic [8:0]  miss_inc;
  logic        miss_hit;
  logic [4:0]  chan_inc;
  logic [3:0]  chan_wrap;
  logic        upper_half;

  always_comb begin
    settle_inc = st.settle_count + 16'd1;
    miss_hit   = (st.miss_count >= MISS_LIMIT);
    miss_inc   = (st.miss_count < MISS_MAX) ? st.miss_count + 9'd1 : st.miss_count;
    chan_inc   = {1'b0, st.scan_channel} + 5'd1;
    chan_wrap  = (chan_inc >= eff_count || chan_inc > LAST_CHANNEL) ? 4'd0 : chan_inc[3:0];
    upper_half = cfg.builtin_volt_mode && (st.scan_channel >= BUILTIN_SPLIT);
  end

  always_comb begin
    st_next = st;
    out     = '0;

    unique case (item.action)
      ACT_LOCK: begin
        st_next.saved_channel  = st.scan_channel;
        st_next.locked_channel = item.lock_channel;
        st_next.lock_mode      = 1'b1;
        st_next.ready_flag     = 1'b0;
        st_next.suspend_flag   = 1'b1;
      end
      ACT_TRIGGER: begin
        st_next.phase = PH_TRIG;
      end
      ACT_RELEASE: begin
        st_next.scan_channel  = st.saved_channel;
        st_next.lock_mode     = 1'b0;
        st_next.lock_switched = 1'b0;
        st_next.phase         = PH_IDLE;
      end
      default: begin
        unique case (st.phase)
          PH_IDLE: begin
            st_next.phase        = PH_OPEN;
            st_next.settle_count = '0;
            st_next.scan_channel = '0;
          end
          PH_OPEN: begin
            st_next.settle_count = '0;
            st_next.phase        = PH_SETTLE;
            if (st.lock_mode) begin
              st_next.lock_switched = 1'b1;
              st_next.scan_channel  = st.locked_channel;
            end
            out.mux_open    = 1'b1;
            out.mux_address = {3'b000, st_next.scan_channel};
          end
          PH_SETTLE: begin
            st_next.settle_count = settle_inc;
            if (settle_inc >= cfg.settle_ticks) begin
              st_next.phase        = (st.lock_mode && st.lock_switched) ? PH_HOLD : PH_TRIG;
              st_next.settle_count = '0;
            end
          end
          PH_TRIG: begin
            st_next.suspend_flag = 1'b1;
            st_next.miss_count   = '0;
            st_next.phase        = PH_WAIT;
            out.trigger_convert  = 1'b1;
          end
          PH_WAIT: begin
            st_next.phase = PH_READ_I;
          end
          PH_READ_I: begin
            if (!item.ready_current_n) begin
              if (item.sample_code != 24'd0 && !upper_half) begin
                out.store_kind    = STORE_CURRENT;
                out.store_channel = st.scan_channel;
                out.store_code    = item.sample_code;
              end
              st_next.phase = PH_READ_V;
            end else begin
              st_next.miss_count = miss_inc;
              if (miss_hit) begin
                out.reinit_converter  = REINIT_CURRENT;
                st_next.scan_channel  = '0;
                st_next.saved_channel = '0;
                st_next.phase         = PH_IDLE;
                st_next.lock_mode     = 1'b0;
                st_next.lock_switched = 1'b0;
              end
            end
          end
          PH_READ_V: begin
            if (!item.ready_voltage_n) begin
              if (item.sample_code != 24'd0) begin
                if (upper_half) begin
                  out.store_kind    = STORE_BUILTIN;
                  out.store_channel = st.scan_channel - BUILTIN_SPLIT;
                end else begin
                  out.store_kind    = STORE_VOLTAGE;
                  out.store_channel = st.scan_channel;
                end
                out.store_code = item.sample_code;
              end
              st_next.phase = PH_CLOSE;
              if (cfg.discharge_park_enable && !st.lock_mode) begin
                out.mux_open    = 1'b1;
                out.mux_address = PARK_ADDR;
              end
            end else begin
              st_next.miss_count = miss_inc;
              if (miss_hit) begin
                out.reinit_converter  = REINIT_VOLTAGE;
                st_next.scan_channel  = '0;
                st_next.saved_channel = '0;
                st_next.phase         = PH_IDLE;
                st_next.lock_mode     = 1'b0;
                st_next.lock_switched = 1'b0;
              end
            end
          end
          PH_CLOSE: begin
            st_next.suspend_flag = 1'b0;
            if (!st.lock_mode) begin
              st_next.scan_channel = chan_wrap;
              st_next.phase        = PH_OPEN;
            end else if (st.ready_flag) begin
              st_next.phase = PH_HOLD;
            end else begin
              st_next.scan_channel = st.locked_channel;
              st_next.phase        = PH_OPEN;
            end
          end
          PH_HOLD: begin
            st_next.ready_flag = 1'b1;
          end
          default: begin
            st_next.phase = PH_IDLE;
          end
        endcase
      end
    endcase

    out.suspend_aux = st_next.suspend_flag;
    out.lock_ready  = st_next.ready_flag;
    out.phase       = st_next.phase;
  end

endmodule
